@@ rtl/sckt_pkg.sv @@
// Shared types and codes for the sorted counted key table.
package sckt_pkg;

    localparam int CMD_W  = 2;
    localparam int KEY_W  = 16;
    localparam int CNT_W  = 16;
    localparam int RANK_W = 6;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 7;

    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;
    localparam logic [STAT_W-1:0] STAT_SAT    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_SCAN,
        S_DECIDE,
        S_SHUP,
        S_INS,
        S_SHDN,
        S_RESP
    } state_t;

endpackage

@@ rtl/sckt_req_if.sv @@
// Request channel: command, key and rank.
interface sckt_req_if;
    logic                       valid;
    logic                       ready;
    logic [sckt_pkg::CMD_W-1:0]  cmd;
    logic [sckt_pkg::KEY_W-1:0]  item_key;
    logic [sckt_pkg::RANK_W-1:0] rank;

    modport source (output valid, output cmd, output item_key, output rank, input ready);
    modport sink   (input valid, input cmd, input item_key, input rank, output ready);
endinterface

@@ rtl/sckt_rsp_if.sv @@
// Response channel: status, key, count and occupancy.
interface sckt_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [sckt_pkg::STAT_W-1:0] status;
    logic [sckt_pkg::KEY_W-1:0]  key_out;
    logic [sckt_pkg::CNT_W-1:0]  count_out;
    logic [sckt_pkg::OCC_W-1:0]  occupancy;

    modport source (output valid, output status, output key_out, output count_out,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input key_out, input count_out,
                    input occupancy, output ready);
endinterface

@@ rtl/sorted_counted_key_table_core.sv @@
// Sorted (key, count) table held in a single-port-read, single-port-write memory.
// Entries sit packed in ascending key order in one memory of TABLE_DEPTH words, one
// entry read and one written per cycle. A request is taken only when the sequencer is
// idle; one response follows each request. A read by rank passes through S_RDWAIT
// and S_RESP to the response register. An add or subtract walks the table from rank
// 0 at one entry per cycle until the key or a larger key is found, then an insert
// shifts the larger entries up and a removal shifts them down, again one entry per
// cycle; a plain count change writes the entry in place. The longest request is an
// insert at rank 0 of a nearly full table, set by the single memory read port, plus
// any wait for the response to be taken. The response register frees the table as
// soon as the result is loaded.
module sorted_counted_key_table_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    sckt_req_if.sink    req,
    sckt_rsp_if.source  rsp
);
    import sckt_pkg::*;

    localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IDX_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = KEY_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [IDX_W-1:0]      FULL_N  = IDX_W'(TABLE_DEPTH);

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [IDX_W-1:0]    used_reg, used_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [ADDR_W-1:0]   dst_reg, dst_next;
    logic                pend_reg, pend_next;
    logic                hit_reg, hit_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    logic [STAT_W-1:0]     st_reg, st_next;
    logic [KEY_BITS-1:0]   rkey_reg, rkey_next;
    logic [COUNT_BITS-1:0] rcnt_reg, rcnt_next;

    logic              out_vld_reg, out_vld_next;
    logic [STAT_W-1:0] out_st_reg, out_st_next;
    logic [KEY_W-1:0]  out_key_reg, out_key_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic [OCC_W-1:0]  out_occ_reg, out_occ_next;

    logic [KEY_BITS-1:0]   rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [IDX_W-1:0]      idx_m1;
    logic                  out_free;

    assign rd_key   = rd_data_reg[ENTRY_W-1:COUNT_BITS];
    assign rd_cnt   = rd_data_reg[COUNT_BITS-1:0];
    assign idx_m1   = idx_reg - 1'b1;
    assign out_free = !out_vld_reg || rsp.ready;

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_vld_reg;
    assign rsp.status    = out_st_reg;
    assign rsp.key_out   = out_key_reg;
    assign rsp.count_out = out_cnt_reg;
    assign rsp.occupancy = out_occ_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            pend_reg    <= pend_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        dst_reg     <= dst_next;
        hit_reg     <= hit_next;
        cnt_reg     <= cnt_next;
        st_reg      <= st_next;
        rkey_reg    <= rkey_next;
        rcnt_reg    <= rcnt_next;
        out_st_reg  <= out_st_next;
        out_key_reg <= out_key_next;
        out_cnt_reg <= out_cnt_next;
        out_occ_reg <= out_occ_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        used_next    = used_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        dst_next     = dst_reg;
        pend_next    = pend_reg;
        hit_next     = hit_reg;
        cnt_next     = cnt_reg;
        st_next      = st_reg;
        rkey_next    = rkey_reg;
        rcnt_next    = rcnt_reg;
        out_vld_next = out_vld_reg && !rsp.ready;
        out_st_next  = out_st_reg;
        out_key_next = out_key_reg;
        out_cnt_next = out_cnt_reg;
        out_occ_next = out_occ_reg;
        rd_addr      = idx_reg[ADDR_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = pos_reg[ADDR_W-1:0];
        wr_data      = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next  = req.cmd;
                    key_next  = KEY_BITS'(req.item_key);
                    idx_next  = '0;
                    pend_next = 1'b0;
                    if (req.cmd == CMD_ADD || req.cmd == CMD_SUB)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (req.cmd == CMD_READ && 32'(req.rank) < 32'(used_reg))
                    begin
                        rd_addr    = ADDR_W'(req.rank);
                        state_next = S_RDWAIT;
                    end
                    else
                    begin
                        st_next    = STAT_ABSENT;
                        rkey_next  = '0;
                        rcnt_next  = '0;
                        state_next = S_RESP;
                    end
                end
            end

            S_RDWAIT:
            begin
                st_next    = STAT_OK;
                rkey_next  = rd_key;
                rcnt_next  = rd_cnt;
                state_next = S_RESP;
            end

            // one read issued per cycle, compared the cycle after
            S_SCAN:
            begin
                if (pend_reg && rd_key >= key_reg)
                begin
                    pos_next   = idx_m1;
                    hit_next   = (rd_key == key_reg);
                    cnt_next   = rd_cnt;
                    pend_next  = 1'b0;
                    state_next = S_DECIDE;
                end
                else if (idx_reg == used_reg)
                begin
                    pos_next   = used_reg;
                    hit_next   = 1'b0;
                    pend_next  = 1'b0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    rd_addr   = idx_reg[ADDR_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end

            S_DECIDE:
            begin
                rkey_next  = key_reg;
                state_next = S_RESP;
                if (cmd_reg == CMD_ADD)
                begin
                    if (hit_reg)
                    begin
                        if (cnt_reg == CNT_MAX)
                        begin
                            st_next   = STAT_SAT;
                            rcnt_next = cnt_reg;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_data   = {key_reg, COUNT_BITS'(cnt_reg + 1'b1)};
                            st_next   = STAT_OK;
                            rcnt_next = COUNT_BITS'(cnt_reg + 1'b1);
                        end
                    end
                    else if (used_reg == FULL_N)
                    begin
                        st_next   = STAT_FULL;
                        rcnt_next = '0;
                    end
                    else
                    begin
                        idx_next   = used_reg;
                        state_next = S_SHUP;
                    end
                end
                else
                begin
                    if (!hit_reg)
                    begin
                        st_next   = STAT_ABSENT;
                        rcnt_next = '0;
                    end
                    else if (cnt_reg == COUNT_BITS'(1))
                    begin
                        idx_next   = pos_reg + 1'b1;
                        state_next = S_SHDN;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        wr_data   = {key_reg, COUNT_BITS'(cnt_reg - 1'b1)};
                        st_next   = STAT_OK;
                        rcnt_next = COUNT_BITS'(cnt_reg - 1'b1);
                    end
                end
            end

            // move larger entries up by one, top first
            S_SHUP:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = dst_reg;
                end
                if (idx_reg > pos_reg)
                begin
                    rd_addr   = idx_m1[ADDR_W-1:0];
                    dst_next  = idx_reg[ADDR_W-1:0];
                    idx_next  = idx_m1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_INS;
                end
            end

            S_INS:
            begin
                wr_en      = 1'b1;
                wr_data    = {key_reg, COUNT_BITS'(1)};
                used_next  = used_reg + 1'b1;
                st_next    = STAT_OK;
                rcnt_next  = COUNT_BITS'(1);
                state_next = S_RESP;
            end

            // close the gap left by a removed entry, bottom first
            S_SHDN:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = dst_reg;
                end
                if (idx_reg < used_reg)
                begin
                    rd_addr   = idx_reg[ADDR_W-1:0];
                    dst_next  = idx_m1[ADDR_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    used_next  = used_reg - 1'b1;
                    st_next    = STAT_OK;
                    rcnt_next  = '0;
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    out_st_next  = st_reg;
                    out_key_next = KEY_W'(rkey_reg);
                    out_cnt_next = CNT_W'(rcnt_reg);
                    out_occ_next = OCC_W'(used_reg);
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/sckt_chk.sv @@
// Port-level checks for the sorted counted key table, bound to the table core module.
module sckt_chk #(
    parameter int TABLE_DEPTH = 64
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [sckt_pkg::STAT_W-1:0] status,
    input logic [sckt_pkg::KEY_W-1:0]  key_out,
    input logic [sckt_pkg::CNT_W-1:0]  count_out,
    input logic [sckt_pkg::OCC_W-1:0]  occupancy
);
    import sckt_pkg::*;

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in progress");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(key_out)
            && $stable(count_out) && $stable(occupancy))
        else $error("stalled response changed");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (TABLE_DEPTH > 127) || (32'(occupancy) <= TABLE_DEPTH))
        else $error("occupancy beyond table depth");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STAT_FULL |-> count_out == '0
            && occupancy == OCC_W'(TABLE_DEPTH))
        else $error("full status with wrong count or occupancy");

    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STAT_ABSENT |-> count_out == '0)
        else $error("absent status with nonzero count");

endmodule

bind sorted_counted_key_table_core sckt_chk #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_sckt_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .key_out   (rsp.key_out),
    .count_out (rsp.count_out),
    .occupancy (rsp.occupancy)
);
